// File: rtl/core/box_blur_3x3_edge_aware_macros.svh
// assertion macros used by the checker file
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bb3x3_pkg.sv
// shared constants and the divisor reciprocal table of the 3x3 box blur
package bb3x3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int DIM_W    = 11;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 1;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int OROW_W   = $clog2(MAX_HEIGHT);
	localparam int IROW_W   = 20;
	localparam logic [IROW_W-1:0] ROW_CAP = {IROW_W{1'b1}};

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

	// channel sum of up to nine pixels, plus rounding half
	localparam int SUM_W    = $clog2(9 * 255 + 4 + 1);
	localparam int CNT_W    = 4;
	localparam int RECIP_SH = 20;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int MUL_W    = SUM_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((2**RECIP_SH + 0) / 1);
	localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((2**RECIP_SH + 1) / 2);
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2**RECIP_SH + 2) / 3);
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2**RECIP_SH + 3) / 4);
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2**RECIP_SH + 5) / 6);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2**RECIP_SH + 8) / 9);

	// ceil(2^RECIP_SH / n); exact floor division for all sums in range
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			CNT_W'(1): r = RECIP_1;
			CNT_W'(2): r = RECIP_2;
			CNT_W'(3): r = RECIP_3;
			CNT_W'(4): r = RECIP_4;
			CNT_W'(6): r = RECIP_6;
			CNT_W'(9): r = RECIP_9;
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/box_blur_3x3_edge_aware.sv
// 3x3 edge-aware box blur over a raster-order RGB stream. Pixels enter on the
// in channel (action 0 = pixel, 1 = flush); each pixel position p produces the
// blurred result for position p - frame_width - 1, so after the last pixel of a
// frame the source sends flush beats until the beat with frame_end goes out.
// Pixels that arrive while a frame is draining are dropped, flush beats outside
// draining are ignored. Each mean divides by the count of in-frame neighbors
// (9, 6, 4, 3, 2 or 1) and rounds half up. Items are handled one at a time:
// a dropped or ignored beat leaves the block idle, a beat with no result goes
// through line store read, then window shift and line store write-back, and
// a beat with a result through read, write-back, channel sums, reciprocal
// multiply and output load, which may wait on out_ready. The line stores are
// single synchronous memories read and written back at the input column; a new
// beat is taken once the output register has accepted the previous result,
// which may still wait for its beat. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module box_blur_3x3_edge_aware import bb3x3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [CH_W-1:0]      red_in,
	input  logic [CH_W-1:0]      green_in,
	input  logic [CH_W-1:0]      blue_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      red_out,
	output logic [CH_W-1:0]      green_out,
	output logic [CH_W-1:0]      blue_out,
	output logic                 frame_end
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CFG_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] up_rd_q, mid_rd_q, px_q;
	logic             act_q;

	logic [PIX_W-1:0] win_q [3][3];

	logic [IROW_W-1:0] in_row_q, in_row_d;
	logic [COL_W-1:0]  in_col_q, in_col_d;
	logic [OROW_W-1:0] out_row_q, out_row_d;
	logic [COL_W-1:0]  out_col_q, out_col_d;
	logic              draining_q, draining_d;

	logic [2:0] row_m_q, col_m_q, row_m_d, col_m_d;
	logic       fe_q, fe_d;
	logic       emit;

	logic [SUM_W-1:0] sum_d [3];
	logic [SUM_W-1:0] sum_q [3];
	logic [CNT_W-1:0] n_d, n_q;
	logic [CH_W-1:0]  mean_d [3];
	logic [CH_W-1:0]  mean_q [3];
	logic             mean_fe_q;

	logic take, proceed, mem_re, mem_we, out_free;
	logic [PIX_W-1:0] px_in;

	// effective frame size: zero acts as one, capped at the store size
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > CFG_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = DIM_W'(height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;
	assign proceed  = take && (action ? draining_q : !draining_q);
	assign px_in    = action ? '0 : {red_in, green_in, blue_in};
	assign mem_re   = proceed;
	assign mem_we   = (state_q == S_UPD);
	assign out_free = !out_valid || out_ready;

	// line stores: read at accept, written back in the following cycle at the same column
	always_ff @(posedge clk) begin
		if (mem_re) begin
			up_rd_q  <= upper_mem[in_col_q];
			mid_rd_q <= middle_mem[in_col_q];
			px_q     <= px_in;
			act_q    <= action;
		end
		if (mem_we) begin
			upper_mem[in_col_q]  <= mid_rd_q;
			middle_mem[in_col_q] <= px_q;
		end
	end

	// position bookkeeping for one processed beat
	always_comb begin
		logic              col_last, row_last, drain_set;
		logic              ocol_last, orow_last;
		logic [DIM_W:0]    orow_x;
		logic [DIM_W:0]    ocol_x;
		logic [DIM_W:0]    h_x, w_x;
		col_last  = ({1'b0, in_col_q} + DIM_W'(1)) >= w_eff;
		row_last  = ({1'b0, in_row_q} + (IROW_W+1)'(1)) >= (IROW_W+1)'(h_eff);
		emit      = (in_row_q >= IROW_W'(2)) || ((in_row_q == IROW_W'(1)) && (in_col_q != '0));
		drain_set = !act_q && row_last && col_last;
		h_x       = {1'b0, h_eff};
		w_x       = {1'b0, w_eff};
		orow_x    = (DIM_W+1)'(out_row_q);
		ocol_x    = (DIM_W+1)'(out_col_q);
		ocol_last = (ocol_x + (DIM_W+1)'(1)) >= w_x;
		orow_last = (orow_x + (DIM_W+1)'(1)) >= h_x;

		draining_d = draining_q || drain_set;
		if (col_last) begin
			in_col_d = '0;
			in_row_d = (in_row_q != ROW_CAP) ? in_row_q + IROW_W'(1) : in_row_q;
		end else begin
			in_col_d = in_col_q + COL_W'(1);
			in_row_d = in_row_q;
		end

		// in-frame neighbor rows and columns around the output position
		row_m_d[0] = (orow_x >= (DIM_W+1)'(1)) && (orow_x <= h_x);
		row_m_d[1] = (orow_x + (DIM_W+1)'(1)) <= h_x;
		row_m_d[2] = (orow_x + (DIM_W+1)'(2)) <= h_x;
		col_m_d[0] = (ocol_x >= (DIM_W+1)'(1)) && (ocol_x <= w_x);
		col_m_d[1] = (ocol_x + (DIM_W+1)'(1)) <= w_x;
		col_m_d[2] = (ocol_x + (DIM_W+1)'(2)) <= w_x;
		fe_d       = orow_last && ocol_last;

		out_row_d = out_row_q;
		out_col_d = out_col_q;
		if (emit) begin
			if (fe_d) begin
				out_row_d = '0;
				out_col_d = '0;
				if (draining_d) begin
					draining_d = 1'b0;
					in_row_d   = '0;
					in_col_d   = '0;
				end
			end else if (ocol_last) begin
				out_col_d = '0;
				out_row_d = out_row_q + OROW_W'(1);
			end else begin
				out_col_d = out_col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			draining_q <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (state_q == S_UPD) begin
			in_row_q   <= in_row_d;
			in_col_q   <= in_col_d;
			out_row_q  <= out_row_d;
			out_col_q  <= out_col_d;
			draining_q <= draining_d;
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= px_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			row_m_q <= row_m_d;
			col_m_q <= col_m_d;
			fe_q    <= fe_d;
		end
	end

	// masked channel sums over the window
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_m_q[r] && col_m_q[c]) begin
					sum_d[0] = sum_d[0] + SUM_W'(win_q[r][c][2*CH_W +: CH_W]);
					sum_d[1] = sum_d[1] + SUM_W'(win_q[r][c][CH_W +: CH_W]);
					sum_d[2] = sum_d[2] + SUM_W'(win_q[r][c][0 +: CH_W]);
				end
			end
		end
		n_d = CNT_W'($countones(row_m_q)) * CNT_W'($countones(col_m_q));
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			sum_q     <= sum_d;
			n_q       <= n_d;
			mean_fe_q <= fe_q;
		end
	end

	// round half up, then divide by multiplying with the reciprocal
	always_comb begin
		logic [MUL_W-1:0] prod;
		logic [RECIP_W-1:0] rc;
		rc = recip(n_q);
		for (int ch = 0; ch < 3; ch++) begin
			prod = MUL_W'(sum_q[ch] + SUM_W'(n_q >> 1)) * MUL_W'(rc);
			mean_d[ch] = prod[RECIP_SH +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV) begin
			mean_q <= mean_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (proceed) state_d = S_UPD;
			end
			S_UPD:  state_d = emit ? S_SUM : S_IDLE;
			S_SUM:  state_d = S_DIV;
			S_DIV:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register, refilled in the same cycle its beat completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			red_out   <= mean_q[0];
			green_out <= mean_q[1];
			blue_out  <= mean_q[2];
			frame_end <= mean_fe_q;
		end
	end

endmodule

// File: rtl/core/bb3x3_checker.sv
// port-level checks of the 3x3 box blur, bound to the top level
`include "box_blur_3x3_edge_aware_macros.svh"

module bb3x3_checker import bb3x3_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] red_out,
	input logic [CH_W-1:0] green_out,
	input logic [CH_W-1:0] blue_out,
	input logic            frame_end
);

	// a stalled result beat holds its payload
	`BB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_end), "out beat changed while stalled")

	// a fresh result follows an input beat by exactly the pipeline depth
	`BB_ASSERT_NOW(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 5), "result without input beat five cycles earlier")

	// the block is busy and not taking input while a result is being formed
	`BB_ASSERT_NOW(a_busy_before_out, $rose(out_valid), !$past(in_ready, 1) && !$past(in_ready, 2) && !$past(in_ready, 3), "input taken while a result was in flight")

endmodule

bind box_blur_3x3_edge_aware bb3x3_checker u_bb3x3_checker (.*);
